// ----- design/sensor_frame_checksum_parser_core_macros.svh -----
// Assertion macros used by the checker of the frame parser.
// Every assertion samples on clk_i and is switched off while rst_ni is low.
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_CORE_MACROS_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define SFCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition at one edge forces a consequence at the next edge.
`define SFCP_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- design/sfcp_pkg.sv -----
package sfcp_pkg;

  // Widths of the byte stream and of the reading.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReadingW = 2 * ByteW;

  // Header value after reset.
  localparam logic [ByteW-1:0] HeaderReset = 8'h2C;

  // Result of one byte step, passed from the tracker to the result register.
  typedef struct packed {
    logic                emit;
    logic [ReadingW-1:0] reading;
    logic                checksum_ok;
  } sfcp_result_t;

endpackage

// ----- design/sfcp_frame_tracker.sv -----
module sfcp_frame_tracker
  import sfcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] header_i,
  output sfcp_result_t     result_o
);

  // Frame position: the frame byte that the next step consumes.
  typedef enum logic [2:0] {
    POS_IDLE  = 3'd0,
    POS_HIGH  = 3'd1,
    POS_LOW   = 3'd2,
    POS_DATA3 = 3'd3,
    POS_DATA4 = 3'd4,
    POS_CHECK = 3'd5
  } pos_e;

  pos_e             pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] high_q, high_d;
  logic [ByteW-1:0] low_q, low_d;

  // Position update, running sum and capture of the reading bytes.
  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    high_d   = high_q;
    low_d    = low_q;
    result_o = '{emit: 1'b0, reading: {high_q, low_q}, checksum_ok: 1'b0};
    if (step_i) begin
      case (pos_q)
        POS_HIGH: begin
          high_d = byte_i;
          sum_d  = sum_q + byte_i;
          pos_d  = POS_LOW;
        end
        POS_LOW: begin
          low_d = byte_i;
          sum_d = sum_q + byte_i;
          pos_d = POS_DATA3;
        end
        POS_DATA3: begin
          sum_d = sum_q + byte_i;
          pos_d = POS_DATA4;
        end
        POS_DATA4: begin
          sum_d = sum_q + byte_i;
          pos_d = POS_CHECK;
        end
        POS_CHECK: begin
          result_o.emit        = 1'b1;
          result_o.checksum_ok = (byte_i == sum_q);
          pos_d                = POS_IDLE;
        end
        default: begin
          // Hunting for the header; anything else is dropped.
          if (byte_i == header_i) begin
            sum_d = byte_i;
            pos_d = POS_HIGH;
          end else begin
            pos_d = POS_IDLE;
          end
        end
      endcase
    end
  end

  // Frame position is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_IDLE;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Sum and reading bytes are always written before they are used.
  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    high_q <= high_d;
    low_q  <= low_d;
  end

endmodule

// ----- design/sensor_frame_checksum_parser_core.sv -----
// Six-byte sensor frame parser. Received bytes enter an input register and
// are consumed one per cycle, unless stalled, by the frame tracker, which
// drops bytes until the header value arrives, then collects the reading bytes
// and an 8-bit running sum; the sixth frame byte loads the result register
// with the reading and the checksum flag. A byte request is taken every cycle
// unless stalled. The input side is stalled only while the input register
// holds a byte and the result register holds a stalled result. The user must
// write the header value through the configuration port only while no bytes
// are in flight; the block does not enforce this.
module sensor_frame_checksum_parser_core
  import sfcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [ByteW-1:0]    cfg_wr_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ReadingW-1:0] reading_o,
  output logic                checksum_ok_o
);

  logic [ByteW-1:0]    header_q;
  logic                in_vld_q, in_vld_d;
  logic [ByteW-1:0]    in_byte_q;
  logic                out_vld_q, out_vld_d;
  logic [ReadingW-1:0] reading_q;
  logic                ok_q;
  logic                in_take;
  logic                advance;
  sfcp_result_t        result;

  // The buffered byte moves on whenever the result register can take a result.
  assign advance    = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  // Header register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
    end else if (cfg_wr_en_i) begin
      header_q <= cfg_wr_data_i;
    end
  end

  // Frame position, sum and reading bytes.
  sfcp_frame_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .header_i (header_q),
    .result_o (result)
  );

  // Valid flags of the input and result registers.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = result.emit;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && result.emit) begin
      reading_q <= result.reading;
      ok_q      <= result.checksum_ok;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign reading_o     = reading_q;
  assign checksum_ok_o = ok_q;

endmodule

// ----- design/sfcp_checker.sv -----
`include "sensor_frame_checksum_parser_core_macros.svh"

module sfcp_checker
  import sfcp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [ReadingW-1:0] reading_o,
  input logic                checksum_ok_o
);

  // A stalled result holds its value.
  `SFCP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(reading_o) && $stable(checksum_ok_o), "stalled result changed")

  // The input side is only stalled by a stalled, pending result.
  `SFCP_ASSERT(a_in_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a stalled result")

  // A frame is six bytes long, so a taken result is never followed at once by another.
  `SFCP_ASSERT_NEXT(a_result_spacing, out_valid_o && !out_stall_i, !out_valid_o, "results too close together")

endmodule

bind sensor_frame_checksum_parser_core sfcp_checker u_sfcp_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import sfcp_pkg::*;

  // Frame layout: the header at position 0, then four data bytes, then the checksum.
  localparam logic [2:0] WaitHeader = 3'd0;
  localparam logic [2:0] PosHigh    = 3'd1;
  localparam logic [2:0] PosLow     = 3'd2;
  localparam logic [2:0] PosSum     = 3'd5;
  localparam int unsigned FrameLen  = 6;

  localparam int unsigned WatchdogLimit = 400;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBytes    = 300;

  typedef struct {
    logic [ReadingW-1:0] reading;
    logic                checksum_ok;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_wr_en_i = 1'b0;
  logic [ByteW-1:0]    cfg_wr_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    rx_byte_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ReadingW-1:0] reading_o;
  logic                checksum_ok_o;

  // Shadow copy of the frame tracker.
  logic [ByteW-1:0] header_value;
  logic [2:0]       frame_pos;
  logic [ByteW-1:0] frame_sum;
  logic [ByteW-1:0] high_byte;
  logic [ByteW-1:0] low_byte;

  reading_t    pending_readings[$];
  reading_t    oldest_reading;
  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned bad_frames = 0;
  int unsigned header_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  bit          sender_idle = 1'b0;
  bit          receiver_idle = 1'b0;

  sensor_frame_checksum_parser_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reading_o    (reading_o),
    .checksum_ok_o(checksum_ok_o)
  );

  always #2 clk_i = ~clk_i;

  // Advances the shadow tracker by one byte and queues the reading a finished frame yields.
  task automatic track_byte(input logic [ByteW-1:0] b);
    reading_t r;
    if (frame_pos == WaitHeader || frame_pos >= FrameLen) begin
      if (b == header_value) begin
        frame_sum = b;
        frame_pos = PosHigh;
      end else begin
        frame_pos = WaitHeader;
      end
    end else if (frame_pos == PosSum) begin
      r.reading = {high_byte, low_byte};
      r.checksum_ok = (b == frame_sum);
      if (!r.checksum_ok) bad_frames++;
      pending_readings.push_back(r);
      frame_pos = WaitHeader;
    end else begin
      if (frame_pos == PosHigh) high_byte = b;
      else if (frame_pos == PosLow) low_byte = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 3'd1;
    end
  endtask

  // Sends one byte request, opening a random gap first when sender gaps are on and a burst has run out.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (sender_idle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 12);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          rx_byte_i <= ByteW'($urandom_range(0, 255));
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    track_byte(b);
    bytes_sent++;
  endtask

  // Sends a whole frame; a good one carries the true sum, a bad one a corrupted sum.
  task automatic send_frame(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] hi,
                            input logic [ByteW-1:0] lo, input logic [ByteW-1:0] d3,
                            input logic [ByteW-1:0] d4, input bit good);
    logic [ByteW-1:0] sum;
    sum = hdr + hi + lo + d3 + d4;
    send_byte(hdr);
    send_byte(hi);
    send_byte(lo);
    send_byte(d3);
    send_byte(d4);
    send_byte(good ? sum : sum ^ ByteW'($urandom_range(1, 255)));
  endtask

  // Waits until every reading has arrived and the pipeline has emptied, then writes the header.
  task automatic write_header(input logic [ByteW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    header_value = value;
    header_writes++;
  endtask

  // Frames under the reset header: a dropped byte, a good full-scale frame, and a bad
  // frame that carries the header value as data.
  task automatic test_default_header();
    send_byte(8'h00);
    send_frame(HeaderReset, 8'hFF, 8'hFF, 8'h12, 8'h34, 1'b1);
    send_frame(HeaderReset, HeaderReset, 8'h01, HeaderReset, 8'hFF, 1'b0);
  endtask

  // Frames under the lowest and highest header values.
  task automatic test_header_extremes();
    write_header(8'h00);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    write_header(8'hFF);
    send_frame(8'hFF, 8'h80, 8'h7F, 8'hFF, 8'hFF, 1'b1);
  endtask

  // Mostly well-formed frames with random content, mixed with noise and cut-off frames.
  task automatic run_random_stream(input int unsigned n_bytes);
    int unsigned start;
    int unsigned kind;
    int unsigned k;
    logic [ByteW-1:0] d[4];
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(0, 99);
      foreach (d[i]) begin
        d[i] = ($urandom_range(0, 6) == 0) ? header_value : ByteW'($urandom_range(0, 255));
      end
      if (kind < 75) begin
        send_frame(header_value, d[0], d[1], d[2], d[3], $urandom_range(0, 3) != 0);
      end else if (kind < 90) begin
        send_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        // A frame cut short, so the next bytes are taken as its tail.
        send_byte(header_value);
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) send_byte(d[i]);
      end
    end
  endtask

  // Five header settings, run under four mixes of sender gaps and receiver stalls.
  task automatic test_random_headers();
    logic [ByteW-1:0] hdrs[5];
    hdrs = '{8'h00, 8'hFF, HeaderReset, 8'h00, 8'h00};
    hdrs[3] = ByteW'($urandom_range(0, 255));
    hdrs[4] = ByteW'($urandom_range(0, 255));
    for (int p = 0; p < 5; p++) begin
      write_header(hdrs[p]);
      sender_idle = (p == 1 || p >= 3);
      receiver_idle = (p >= 2);
      run_random_stream(PhaseBytes);
    end
  endtask

  // Receiver stalls in runs of random length.
  always @(posedge clk_i) begin
    if (!receiver_idle) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run == 0) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, 16);
    end else begin
      stall_run--;
    end
  end

  // Compares each accepted result with the oldest expected reading.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result reading %h checksum_ok %b",
                 $time, reading_o, checksum_ok_o);
        error_count++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        frames_checked++;
        if (reading_o !== oldest_reading.reading) begin
          $display("%0t: reading expected %h actual %h",
                   $time, oldest_reading.reading, reading_o);
          error_count++;
        end
        if (checksum_ok_o !== oldest_reading.checksum_ok) begin
          $display("%0t: checksum_ok expected %b actual %b",
                   $time, oldest_reading.checksum_ok, checksum_ok_o);
          error_count++;
        end
      end
    end
  end

  // Ends the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    header_value = HeaderReset;
    frame_pos = WaitHeader;
    frame_sum = '0;
    high_byte = '0;
    low_byte = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_header();
    test_header_extremes();
    test_random_headers();

    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes under %0d header writes after the reset header.",
             bytes_sent, header_writes);
    $display("Checked %0d frames, %0d of them with a bad checksum.",
             frames_checked, bad_frames);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sensor_frame_checksum_parser_core.f -----
+incdir+design
design/sfcp_pkg.sv
design/sfcp_frame_tracker.sv
design/sensor_frame_checksum_parser_core.sv
design/sfcp_checker.sv
bench/tb.sv
